// File: hw/rtl/mmid_pkg.sv
package mmid_pkg;

  // Item operation codes
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned INDEX_W = 8;

  // Fixed-width part of a token moving down the cell chain.
  // data_a carries the instruction on a decode and the care mask on a load;
  // data_b carries the expected value on a load.
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [WORD_W-1:0] data_a;
    logic [WORD_W-1:0] data_b;
    logic              full;
    logic              found;
  } token_t;

endpackage

// File: hw/rtl/mmid_in_if.sv
interface mmid_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] instruction;
  logic [31:0] pattern_mask;
  logic [31:0] pattern_value;

  modport source (output valid, output operation, output instruction,
                  output pattern_mask, output pattern_value, input ready);
  modport sink   (input valid, input operation, input instruction,
                  input pattern_mask, input pattern_value, output ready);
endinterface

interface mmid_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] match_index;
  logic       table_full;

  modport source (output valid, output found, output match_index,
                  output table_full, input ready);
  modport sink   (input valid, input found, input match_index,
                  input table_full, output ready);
endinterface

// File: hw/rtl/mask_match_instruction_decoder.sv
// Mask-and-match priority instruction decoder. Load beats append a care mask
// and expected value to a table of MAX_PATTERNS entries; a load into a full
// table stores nothing and returns table_full. A decode beat returns the
// first pattern in load order with (instruction & mask) == value, or
// found = 0 and index 0. Each table entry lives in one cell of a chain of
// MAX_PATTERNS cells; every beat walks the chain one cell per cycle and
// then enters the output register, and one beat per cycle is accepted
// when the output side keeps up. A stall at the
// output freezes the whole chain. Match indexes above 255 wrap to their low
// eight bits. No clearing pass follows reset.
module mask_match_instruction_decoder #(
  parameter int unsigned MAX_PATTERNS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mmid_in_if.sink           in_i,
  mmid_out_if.source        out_o
);

  localparam int unsigned IdxW = $clog2(MAX_PATTERNS + 1);
  localparam logic [IdxW-1:0] MaxCount = IdxW'(MAX_PATTERNS);

  mmid_pkg::token_t tok   [MAX_PATTERNS+1];
  logic [IdxW-1:0]  ref_w [MAX_PATTERNS+1];
  logic [IdxW-1:0]  hit_w [MAX_PATTERNS+1];

  logic            advance, accept, is_load, is_full;
  logic [IdxW-1:0] count_d, count_q;
  logic            out_valid_q, found_q, full_q;
  logic [7:0]      index_q;
  logic [IdxW+7:0] hit_ext;

  // The chain moves whenever the output register can take a beat
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;
  assign accept     = in_i.valid && advance;
  assign is_load    = (mmid_pkg::op_e'(in_i.operation) == mmid_pkg::OP_LOAD);
  assign is_full    = (count_q == MaxCount);

  // Build the head token
  always_comb begin
    tok[0].valid  = accept;
    tok[0].op     = mmid_pkg::op_e'(in_i.operation);
    tok[0].data_a = is_load ? in_i.pattern_mask : in_i.instruction;
    tok[0].data_b = in_i.pattern_value;
    tok[0].full   = is_load && is_full;
    tok[0].found  = 1'b0;
  end
  assign ref_w[0] = count_q;
  assign hit_w[0] = '0;

  // Advance the pattern count on each stored load
  always_comb begin
    count_d = count_q;
    if (accept && is_load && !is_full) begin
      count_d = count_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Row of pattern cells
  for (genvar g = 0; g < MAX_PATTERNS; g++) begin : g_cell
    mmid_cell #(
      .IDX_W (IdxW),
      .IDX   (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .tok_i  (tok[g]),
      .ref_i  (ref_w[g]),
      .hit_i  (hit_w[g]),
      .tok_o  (tok[g+1]),
      .ref_o  (ref_w[g+1]),
      .hit_o  (hit_w[g+1])
    );
  end

  assign hit_ext = {8'b0, hit_w[MAX_PATTERNS]};

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= tok[MAX_PATTERNS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && tok[MAX_PATTERNS].valid) begin
      found_q <= tok[MAX_PATTERNS].found;
      full_q  <= tok[MAX_PATTERNS].full;
      index_q <= tok[MAX_PATTERNS].found ? hit_ext[7:0] : 8'd0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = found_q;
  assign out_o.match_index = index_q;
  assign out_o.table_full  = full_q;

endmodule

// File: hw/rtl/mmid_cell.sv
module mmid_cell #(
  parameter int unsigned IDX_W = 9,
  parameter int unsigned IDX   = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  mmid_pkg::token_t    tok_i,
  input  logic [IDX_W-1:0]    ref_i,
  input  logic [IDX_W-1:0]    hit_i,
  output mmid_pkg::token_t    tok_o,
  output logic [IDX_W-1:0]    ref_o,
  output logic [IDX_W-1:0]    hit_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [mmid_pkg::WORD_W-1:0] mask_q, value_q;
  mmid_pkg::token_t            tok_d, tok_q;
  logic [IDX_W-1:0]            ref_q, hit_d, hit_q;
  logic                        wr_en, match;

  // Store the pattern when a load token targets this slot
  assign wr_en = en_i && tok_i.valid && (tok_i.op == mmid_pkg::OP_LOAD) &&
                 !tok_i.full && (ref_i == MyIdx);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mask_q  <= tok_i.data_a;
      value_q <= tok_i.data_b;
    end
  end

  // Compare only slots below the count seen when the decode entered
  assign match = tok_i.valid && (tok_i.op == mmid_pkg::OP_DECODE) &&
                 !tok_i.found && (MyIdx < ref_i) &&
                 ((tok_i.data_a & mask_q) == value_q);

  always_comb begin
    tok_d = tok_i;
    hit_d = hit_i;
    if (match) begin
      tok_d.found = 1'b1;
      hit_d       = MyIdx;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (en_i) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ref_q <= ref_i;
      hit_q <= hit_d;
    end
  end

  assign tok_o = tok_q;
  assign ref_o = ref_q;
  assign hit_o = hit_q;

endmodule

// File: hw/rtl/mmid_checker.sv
module mmid_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_found_i,
  input logic [7:0] out_index_i,
  input logic       out_full_i
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_found_i) &&
    $stable(out_index_i) && $stable(out_full_i))
    else $error("stalled result beat changed");

  // Input stalls only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // A result never reports both a match and a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_found_i && out_full_i))
    else $error("found and table_full both set");

  // A miss reports index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_index_i == 8'd0)
    else $error("nonzero index without a match");

  // Nothing comes out in the first cycle after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result beat right after reset");

endmodule

bind mask_match_instruction_decoder mmid_checker u_mmid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_found_i (out_o.found),
  .out_index_i (out_o.match_index),
  .out_full_i  (out_o.table_full)
);
